### sv/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned MASTER_W = 20;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FAIL_W   = 2;
  localparam int unsigned COUNT_W  = 3;

  // Master code after reset: every digit is one.
  localparam logic [MASTER_W-1:0] MASTER_RESET = 20'h11111;

  // Request kinds carried by req_type.
  localparam logic REQ_KEY    = 1'b0;
  localparam logic REQ_MASTER = 1'b1;

  // Lock mode, also the state of the controller.
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_MASTER  = 2'd1,
    MODE_NEWCODE = 2'd2
  } mode_t;

  // Event reported with each result.
  typedef enum logic [EVENT_W-1:0] {
    EV_DIGIT        = 3'd0,
    EV_GRANTED      = 3'd1,
    EV_DENIED       = 3'd2,
    EV_LOCKOUT      = 3'd3,
    EV_MASTER_WRONG = 3'd4,
    EV_MASTER_OK    = 3'd5,
    EV_CHANGED      = 3'd6
  } event_t;

  // One input beat.
  typedef struct packed {
    logic               req_type;
    logic [DIGIT_W-1:0] key_digit;
  } req_t;

  // One result beat.
  typedef struct packed {
    event_t             event_code;
    logic               unlock;
    mode_t              lock_mode;
    logic [FAIL_W-1:0]  failures;
    logic [COUNT_W-1:0] digits_entered;
  } res_t;

endpackage

`default_nettype wire

### sv/kcl_ifs.sv
`default_nettype none

// Key event channel.
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [3:0] key_digit;

  modport source (output valid, req_type, key_digit, input ready);
  modport sink   (input valid, req_type, key_digit, output ready);
endinterface

// Result channel.
interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       unlock;
  logic [1:0] lock_mode;
  logic [1:0] failures;
  logic [2:0] digits_entered;

  modport source (output valid, event_code, unlock, lock_mode, failures, digits_entered,
                  input ready);
  modport sink   (input valid, event_code, unlock, lock_mode, failures, digits_entered,
                  output ready);
endinterface

// Master code write channel.
interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] master_code;

  modport source (output valid, master_code, input ready);
  modport sink   (input valid, master_code, output ready);
endinterface

`default_nettype wire

### sv/kcl_lock_core.sv
`default_nettype none

module kcl_lock_core
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = 5,
  parameter int unsigned MAX_FAILS   = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire req_t                beat,
  input  wire logic [MASTER_W-1:0] master_code,
  output res_t                     res
);

  localparam int unsigned PW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(CODE_DIGITS - 1);

  mode_t             mode_r, mode_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              mis_r, mis_nxt;
  logic [FAIL_W-1:0] fail_r, fail_nxt;
  logic [DIGIT_W-1:0] stored_r [CODE_DIGITS];

  logic               last;
  logic               mis_now;
  logic [2:0]         nib_idx;
  logic [31:0]        master_ext;
  logic [DIGIT_W-1:0] master_nib;
  logic [DIGIT_W-1:0] stored_nib;
  logic               store_en;
  event_t             ev;
  logic               unlock;

  // Digit of each code that lines up with the current entry position.
  assign master_ext = 32'(master_code);
  assign nib_idx    = 3'(CODE_DIGITS - 1) - 3'(pos_r);
  assign master_nib = master_ext[nib_idx*4 +: 4];
  assign stored_nib = stored_r[pos_r];
  assign last       = (pos_r == LAST_POS);

  // Next state and result for the beat in the input register.
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    mis_nxt  = mis_r;
    fail_nxt = fail_r;
    ev       = EV_DIGIT;
    unlock   = 1'b0;
    store_en = 1'b0;
    mis_now  = mis_r;
    if (beat.req_type == REQ_MASTER) begin
      pos_nxt  = '0;
      mis_nxt  = 1'b0;
      mode_nxt = MODE_MASTER;
    end else begin
      unique case (mode_r)
        MODE_NEWCODE: begin
          store_en = 1'b1;
          if (last) begin
            ev       = EV_CHANGED;
            mode_nxt = MODE_NORMAL;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
        MODE_MASTER: begin
          mis_now = mis_r | (beat.key_digit != master_nib);
          if (last) begin
            fail_nxt = '0;
            if (mis_now) begin
              ev = EV_MASTER_WRONG;
            end else begin
              ev       = EV_MASTER_OK;
              mode_nxt = MODE_NEWCODE;
            end
            mis_nxt = 1'b0;
            pos_nxt = '0;
          end else begin
            mis_nxt = mis_now;
            pos_nxt = pos_r + 1'b1;
          end
        end
        default: begin
          mis_now = mis_r | (beat.key_digit != stored_nib);
          if (last) begin
            if (!mis_now) begin
              ev       = EV_GRANTED;
              unlock   = 1'b1;
              fail_nxt = '0;
            end else if (({1'b0, fail_r} + 3'd1) >= 3'(MAX_FAILS)) begin
              ev       = EV_LOCKOUT;
              mode_nxt = MODE_MASTER;
            end else begin
              ev       = EV_DENIED;
              fail_nxt = fail_r + 1'b1;
            end
            mis_nxt = 1'b0;
            pos_nxt = '0;
          end else begin
            mis_nxt = mis_now;
            pos_nxt = pos_r + 1'b1;
          end
        end
      endcase
    end
  end

  assign res.event_code     = ev;
  assign res.unlock         = unlock;
  assign res.lock_mode      = mode_nxt;
  assign res.failures       = fail_nxt;
  assign res.digits_entered = COUNT_W'(pos_nxt);

  // Mode state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

  // Entry progress and failure count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mis_r  <= 1'b0;
      fail_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      mis_r  <= mis_nxt;
      fail_r <= fail_nxt;
    end
  end

  // Stored user code, one digit written per beat in new-code mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(CODE_DIGITS); i++) begin
        stored_r[i] <= '0;
      end
    end else if (step && store_en) begin
      stored_r[pos_r] <= beat.key_digit;
    end
  end

  // The failure count never reaches the lockout threshold.
  a_fail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fail_r} < 3'(MAX_FAILS)) || (fail_r == '0))
    else $error("failure count at or above lockout threshold");

  // The entry position stays inside the code.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("entry position beyond last digit");

  // An unlock only comes with a grant, which closes the entry.
  a_unlock_grant: assert property (@(posedge clk) disable iff (!rst_n)
    unlock |-> (ev == EV_GRANTED) && (pos_nxt == '0) && (fail_nxt == '0))
    else $error("unlock without a completed matching entry");

endmodule

`default_nettype wire

### sv/keypad_code_lock_controller.sv
// Keypad code lock controller.
// in_ch carries one key event per beat: a decoded digit (req_type 0) or a
// master request (req_type 1). out_ch returns exactly one result beat per
// input beat, in order: event code, unlock flag, mode, failure count and
// digits collected so far. cfg_ch writes the 20-bit master code; it is
// always ready and should be written only while no item is in flight.
// An accepted beat lands in an input register; the lock logic evaluates it
// and loads the result into the output register once that register is free
// or being drained. Input and output registers form a two-stage pipeline
// and one beat is taken every cycle while out_ch.ready is high; the state
// update is a single compare and increment per beat.
// When the receiver stalls, the pending result holds in the output register
// and one more beat is taken into the input register, then in_ch.ready
// drops until the result drains.
// Synchronous active-low reset returns to normal mode with no digits
// entered, clears the failure count, zeroes the stored code and sets every
// digit of the master code to one.
`default_nettype none

module keypad_code_lock_controller
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = 5,
  parameter int unsigned MAX_FAILS   = 3
) (
  input wire logic   clk,
  input wire logic   rst_n,
  kcl_in_if.sink     in_ch,
  kcl_out_if.source  out_ch,
  kcl_cfg_if.sink    cfg_ch
);

  logic                in_vld_r;
  req_t                in_beat_r;
  logic                out_vld_r;
  res_t                out_res_r;
  logic [MASTER_W-1:0] master_r;
  logic                step;
  res_t                core_res;
  req_t                in_beat;

  assign in_beat.req_type  = in_ch.req_type;
  assign in_beat.key_digit = in_ch.key_digit;

  // A beat advances when the output register is free or being drained.
  assign step        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || step;
  assign cfg_ch.ready = 1'b1;

  // Master code register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_RESET;
    end else if (cfg_ch.valid) begin
      master_r <= cfg_ch.master_code;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_beat_r <= in_beat;
    end
  end

  kcl_lock_core #(
    .CODE_DIGITS (CODE_DIGITS),
    .MAX_FAILS   (MAX_FAILS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .beat        (in_beat_r),
    .master_code (master_r),
    .res         (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.event_code     = out_res_r.event_code;
  assign out_ch.unlock         = out_res_r.unlock;
  assign out_ch.lock_mode      = out_res_r.lock_mode;
  assign out_ch.failures       = out_res_r.failures;
  assign out_ch.digits_entered = out_res_r.digits_entered;

  // Every evaluated beat shows up as a result at the next edge.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("evaluated beat produced no result");

  // With both registers full and the receiver stalled, no beat is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_ch.ready) |-> !in_ch.ready && !step)
    else $error("beat taken while pipeline full and stalled");

  // A stalled result stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> out_vld_r && $stable(out_res_r))
    else $error("result changed while the receiver stalled");

endmodule

`default_nettype wire
